// File: design/composite_artifact_colour_model_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the composite colour model checks.
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_ARTIFACT_COLOUR_MODEL_CORE_ASSERT_SVH
`define COMPOSITE_ARTIFACT_COLOUR_MODEL_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset
`define CACM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("composite colour model check failed");

// Next-cycle implication, sampled on i_clk, off while in reset
`define CACM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("composite colour model check failed");

`endif

// File: design/cacm_pkg.sv
// ----------------------------------------------------------------------------
// cacm_pkg
// Types, widths and constants of the composite colour model pipeline.
// ----------------------------------------------------------------------------
package cacm_pkg;

    // Table geometry and sample precision
    localparam int TRANSITION_ENTRIES = 512;
    localparam int SAMPLE_BITS        = 16;
    localparam int BANK_DEPTH         = (TRANSITION_ENTRIES + 3) / 4;
    localparam int BANK_AW            = $clog2(BANK_DEPTH);

    // Register stages from input transfer to output register
    localparam int PIPE_STAGES = 11;

    // Fixed field widths
    localparam int IDX_W     = 9;
    localparam int VAL_W     = 16;
    localparam int CAP_W     = 16;
    localparam int OUT_W     = 16;
    localparam int ERR_W     = 36;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Datapath widths
    localparam int S_W    = SAMPLE_BITS + 1;
    localparam int SUM_W  = SAMPLE_BITS + 3;
    localparam int DIFF_W = SAMPLE_BITS + 2;
    localparam int YM_W   = SUM_W + CFG_W;
    localparam int Y_W    = YM_W + 2;
    localparam int PR_W   = DIFF_W + CFG_W;
    localparam int CH_W   = PR_W + 4;
    localparam int K_W    = 16;
    localparam int PY_W   = Y_W + K_W;
    localparam int PA_W   = CH_W + K_W;
    localparam int N_W    = PA_W + 2;
    localparam int M_W    = N_W + 7;
    localparam int SCALE  = SAMPLE_BITS + 16;
    localparam int Q_W    = M_W - SCALE;
    localparam int BRIGHT_SH = SAMPLE_BITS + 2;

    // Rounding and divide by 125 through a reciprocal
    localparam int RND_MUL  = 51;
    localparam logic signed [M_W-1:0] ROUND_BIAS = M_W'(125) << (SCALE - 1);
    localparam int SAT_LIM  = 125 * 32768;
    localparam logic signed [Q_W-1:0] Q_LIM = Q_W'(SAT_LIM);
    localparam int X_W      = $clog2(2 * SAT_LIM);
    localparam int XL_W     = 11;
    localparam int XH_W     = X_W - XL_W;
    localparam int RECIP_SH = 30;
    localparam int C_W      = 24;
    localparam logic [C_W-1:0] C_REC = C_W'((2 ** RECIP_SH + 124) / 125);
    localparam int P_W      = X_W + C_W;
    localparam int QUO_W    = P_W - RECIP_SH;
    localparam logic [QUO_W-1:0] OUT_OFS = QUO_W'(1) << (OUT_W - 1);
    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7fff;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;
    localparam int SQ_W     = 2 * (OUT_W + 1);

    // YIQ to RGB coefficients in units of 1/10000
    localparam logic signed [K_W-1:0] KY   = 16'sd10000;
    localparam logic signed [K_W-1:0] KA_R = 16'sd9563;
    localparam logic signed [K_W-1:0] KB_R = 16'sd6210;
    localparam logic signed [K_W-1:0] KA_G = -16'sd2721;
    localparam logic signed [K_W-1:0] KB_G = -16'sd6474;
    localparam logic signed [K_W-1:0] KA_B = -16'sd11069;
    localparam logic signed [K_W-1:0] KB_B = 16'sd17046;

    // Item kinds
    localparam logic [1:0] KIND_EVAL  = 2'd0;
    localparam logic [1:0] KIND_TRANS = 2'd1;
    localparam logic [1:0] KIND_INT   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_IM = 3'd3;
    localparam logic [CFG_W-1:0]     CONTRAST_RESET = 16'd16384;

    typedef logic [SAMPLE_BITS-1:0]      t_sample;
    typedef logic [3:0][SAMPLE_BITS-1:0] t_quad;

    typedef struct packed {
        logic [1:0]              kind;
        logic [3:0]              foreground;
        logic [3:0]              background;
        logic [3:0]              pattern;
        logic [IDX_W-1:0]        table_index;
        logic [VAL_W-1:0]        table_value;
        logic signed [CAP_W-1:0] captured_red;
        logic signed [CAP_W-1:0] captured_green;
        logic signed [CAP_W-1:0] captured_blue;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] red;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] blue;
        logic [ERR_W-1:0]        squared_error;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0]        contrast_gain;
        logic signed [CFG_W-1:0] brightness_offset;
        logic signed [CFG_W-1:0] chroma_mult_real;
        logic signed [CFG_W-1:0] chroma_mult_imag;
    } t_cfg;

    typedef struct packed {
        logic             trans_we;
        logic             int_we;
        logic [IDX_W-1:0] index;
        t_sample          value;
    } t_tbl_wr;

    typedef struct packed {
        logic signed [CAP_W-1:0] red;
        logic signed [CAP_W-1:0] green;
        logic signed [CAP_W-1:0] blue;
    } t_cap;

endpackage

// File: design/cacm_lookup.sv
// ----------------------------------------------------------------------------
// cacm_lookup
// Transition sample banks (one per phase), intensity copies and the
// post-reset clear sweep. Produces the four phase samples one stage in.
// ----------------------------------------------------------------------------
module cacm_lookup (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  cacm_pkg::t_in_item   i_item,
    input  cacm_pkg::t_tbl_wr    i_wr,
    output logic                 o_clr_busy,
    output cacm_pkg::t_quad      o_trans,
    output cacm_pkg::t_quad      o_inten,
    output logic [3:0]           o_ok
);

    logic                          r_clr_busy;
    logic [cacm_pkg::BANK_AW-1:0]  r_clr_addr;
    cacm_pkg::t_sample             r_int [4][4];
    cacm_pkg::t_quad               r_trans;
    cacm_pkg::t_quad               r_inten;
    logic [3:0]                    r_ok;

    // Sweep every bank row to half scale after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == cacm_pkg::BANK_AW'(cacm_pkg::BANK_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Intensity table, one copy per phase so each is read at one address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 4; p++) begin
                for (int e = 0; e < 4; e++) begin
                    r_int[p][e] <= '0;
                end
            end
        end else if (i_wr.int_we) begin
            for (int p = 0; p < 4; p++) begin
                r_int[p][i_wr.index[1:0]] <= i_wr.value;
            end
        end
    end

    for (genvar p = 0; p < 4; p++) begin : g_bank
        localparam int LB = 3 - p;
        localparam int RB = 3 - ((p + 1) % 4);

        logic [3:0]                   left_c;
        logic [3:0]                   right_c;
        logic [cacm_pkg::IDX_W-1:0]   ti;
        logic [1:0]                   ii;
        logic                         we;
        logic [cacm_pkg::BANK_AW-1:0] waddr;
        cacm_pkg::t_sample            wdata;
        cacm_pkg::t_sample            r_mem [cacm_pkg::BANK_DEPTH];

        // Form the transition and intensity addresses of this phase
        always_comb begin
            left_c  = i_item.pattern[LB] ? i_item.foreground : i_item.background;
            right_c = i_item.pattern[RB] ? i_item.foreground : i_item.background;
            ti      = {left_c[2:0], 1'b0, right_c[2:0], 2'(p)};
            ii      = {right_c[3], left_c[3]};
        end

        // Share the write port between the sweep and table transfers
        always_comb begin
            we    = r_clr_busy || (i_wr.trans_we && (i_wr.index[1:0] == 2'(p)));
            waddr = r_clr_busy ? r_clr_addr : cacm_pkg::BANK_AW'(i_wr.index[8:2]);
            wdata = r_clr_busy ? (cacm_pkg::t_sample'(1) << (cacm_pkg::SAMPLE_BITS - 1))
                               : i_wr.value;
        end

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_mem[waddr] <= wdata;
            end
            if (i_en) begin
                r_trans[p] <= r_mem[cacm_pkg::BANK_AW'(ti[8:2])];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_inten[p] <= r_int[p][ii];
                r_ok[p]    <= (32'(ti) < cacm_pkg::TRANSITION_ENTRIES);
            end
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_trans    = r_trans;
    assign o_inten    = r_inten;
    assign o_ok       = r_ok;

endmodule

// File: design/cacm_mix.sv
// ----------------------------------------------------------------------------
// cacm_mix
// Phase sums, contrast and brightness for luma, and the complex chroma
// multiply. Three register stages.
// ----------------------------------------------------------------------------
module cacm_mix (
    input  logic                                i_clk,
    input  logic [2:0]                          i_en,
    input  cacm_pkg::t_quad                     i_trans,
    input  cacm_pkg::t_quad                     i_inten,
    input  logic [3:0]                          i_ok,
    input  cacm_pkg::t_cfg                      i_cfg,
    output logic signed [cacm_pkg::Y_W-1:0]     o_y,
    output logic signed [cacm_pkg::CH_W-1:0]    o_ix,
    output logic signed [cacm_pkg::CH_W-1:0]    o_iq
);

    logic [cacm_pkg::S_W-1:0]            s [4];
    logic [cacm_pkg::SUM_W-1:0]          n_sum4, r_sum4;
    logic signed [cacm_pkg::DIFF_W-1:0]  n_dx, r_dx, n_dy, r_dy;
    logic [cacm_pkg::YM_W-1:0]           n_ym, r_ym;
    logic signed [cacm_pkg::PR_W-1:0]    n_prr, r_prr, n_pii, r_pii;
    logic signed [cacm_pkg::PR_W-1:0]    n_pri, r_pri, n_pir, r_pir;
    logic signed [cacm_pkg::Y_W-1:0]     n_y, r_y;
    logic signed [cacm_pkg::CH_W-1:0]    n_ix, r_ix, n_iq, r_iq;

    // Phase samples, their sum and the two quadrature differences
    always_comb begin
        for (int p = 0; p < 4; p++) begin
            s[p] = (i_ok[p] ? cacm_pkg::S_W'(i_trans[p]) : '0)
                 + cacm_pkg::S_W'(i_inten[p]);
        end
        n_sum4 = cacm_pkg::SUM_W'(s[0]) + cacm_pkg::SUM_W'(s[1])
               + cacm_pkg::SUM_W'(s[2]) + cacm_pkg::SUM_W'(s[3]);
        n_dx = $signed(cacm_pkg::DIFF_W'(s[0])) - $signed(cacm_pkg::DIFF_W'(s[2]));
        n_dy = $signed(cacm_pkg::DIFF_W'(s[1])) - $signed(cacm_pkg::DIFF_W'(s[3]));
    end

    // Contrast and the four chroma partial products
    always_comb begin
        n_ym  = cacm_pkg::YM_W'(r_sum4) * cacm_pkg::YM_W'(i_cfg.contrast_gain);
        n_prr = cacm_pkg::PR_W'(r_dx) * cacm_pkg::PR_W'($signed(i_cfg.chroma_mult_real));
        n_pii = cacm_pkg::PR_W'(r_dy) * cacm_pkg::PR_W'($signed(i_cfg.chroma_mult_imag));
        n_pri = cacm_pkg::PR_W'(r_dx) * cacm_pkg::PR_W'($signed(i_cfg.chroma_mult_imag));
        n_pir = cacm_pkg::PR_W'(r_dy) * cacm_pkg::PR_W'($signed(i_cfg.chroma_mult_real));
    end

    // Brightness and the rotated chroma pair
    always_comb begin
        n_y  = cacm_pkg::Y_W'($signed({1'b0, r_ym}))
             + (cacm_pkg::Y_W'($signed(i_cfg.brightness_offset)) <<< cacm_pkg::BRIGHT_SH);
        n_ix = (cacm_pkg::CH_W'(r_prr) - cacm_pkg::CH_W'(r_pii)) <<< 3;
        n_iq = (cacm_pkg::CH_W'(r_pri) + cacm_pkg::CH_W'(r_pir)) <<< 3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum4 <= n_sum4;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
        end
        if (i_en[1]) begin
            r_ym  <= n_ym;
            r_prr <= n_prr;
            r_pii <= n_pii;
            r_pri <= n_pri;
            r_pir <= n_pir;
        end
        if (i_en[2]) begin
            r_y  <= n_y;
            r_ix <= n_ix;
            r_iq <= n_iq;
        end
    end

    assign o_y  = r_y;
    assign o_ix = r_ix;
    assign o_iq = r_iq;

endmodule

// File: design/cacm_chan.sv
// ----------------------------------------------------------------------------
// cacm_chan
// One RGB channel: coefficient products, rounding, divide by 125 through
// a split reciprocal multiply, saturation and the squared error.
// ----------------------------------------------------------------------------
module cacm_chan (
    input  logic                               i_clk,
    input  logic [5:0]                         i_en,
    input  logic signed [cacm_pkg::Y_W-1:0]    i_y,
    input  logic signed [cacm_pkg::CH_W-1:0]   i_ix,
    input  logic signed [cacm_pkg::CH_W-1:0]   i_iq,
    input  logic signed [cacm_pkg::K_W-1:0]    i_ka,
    input  logic signed [cacm_pkg::K_W-1:0]    i_kb,
    input  logic signed [cacm_pkg::CAP_W-1:0]  i_cap,
    output logic signed [cacm_pkg::OUT_W-1:0]  o_ch,
    output logic [cacm_pkg::SQ_W-1:0]          o_sq
);

    logic signed [cacm_pkg::PY_W-1:0]    n_py, r_py;
    logic signed [cacm_pkg::PA_W-1:0]    n_pa, r_pa, n_pb, r_pb;
    logic signed [cacm_pkg::N_W-1:0]     n_n, r_n;
    logic signed [cacm_pkg::M_W-1:0]     m;
    logic signed [cacm_pkg::Q_W-1:0]     q;
    logic                                n_hi, r_hi7, r_hi8, n_lo, r_lo7, r_lo8;
    logic [cacm_pkg::X_W-1:0]            n_x, r_x;
    logic [cacm_pkg::XH_W+cacm_pkg::C_W-1:0] n_ph, r_ph;
    logic [cacm_pkg::XL_W+cacm_pkg::C_W-1:0] n_pl, r_pl;
    logic [cacm_pkg::P_W-1:0]            prod;
    logic [cacm_pkg::QUO_W-1:0]          quo;
    logic signed [cacm_pkg::OUT_W-1:0]   n_ch, r_ch9, r_ch10;
    logic signed [cacm_pkg::OUT_W:0]     n_d, r_d;
    logic [cacm_pkg::SQ_W-1:0]           n_sq, r_sq;

    // Coefficient products
    always_comb begin
        n_py = cacm_pkg::PY_W'(i_y) * cacm_pkg::PY_W'(cacm_pkg::KY);
        n_pa = cacm_pkg::PA_W'(i_ix) * cacm_pkg::PA_W'(i_ka);
        n_pb = cacm_pkg::PA_W'(i_iq) * cacm_pkg::PA_W'(i_kb);
        n_n  = cacm_pkg::N_W'(r_py) + cacm_pkg::N_W'(r_pa) + cacm_pkg::N_W'(r_pb);
    end

    // Scale by 51, add the half-step bias, drop the fraction, flag saturation
    always_comb begin
        m    = cacm_pkg::M_W'(r_n) * cacm_pkg::M_W'(cacm_pkg::RND_MUL)
             + cacm_pkg::ROUND_BIAS;
        q    = $signed(m[cacm_pkg::M_W-1:cacm_pkg::SCALE]);
        n_hi = (q >= cacm_pkg::Q_LIM);
        n_lo = (q < -cacm_pkg::Q_LIM);
        n_x  = cacm_pkg::X_W'(q + cacm_pkg::Q_LIM);
    end

    // Reciprocal of 125 in two partial products
    always_comb begin
        n_ph = (cacm_pkg::XH_W + cacm_pkg::C_W)'(r_x[cacm_pkg::X_W-1:cacm_pkg::XL_W])
             * (cacm_pkg::XH_W + cacm_pkg::C_W)'(cacm_pkg::C_REC);
        n_pl = (cacm_pkg::XL_W + cacm_pkg::C_W)'(r_x[cacm_pkg::XL_W-1:0])
             * (cacm_pkg::XL_W + cacm_pkg::C_W)'(cacm_pkg::C_REC);
    end

    // Quotient, re-center, saturate and take the difference to capture
    always_comb begin
        prod = (cacm_pkg::P_W'(r_ph) << cacm_pkg::XL_W) + cacm_pkg::P_W'(r_pl);
        quo  = prod[cacm_pkg::P_W-1:cacm_pkg::RECIP_SH];
        if (r_hi8) begin
            n_ch = cacm_pkg::OUT_MAX;
        end else if (r_lo8) begin
            n_ch = cacm_pkg::OUT_MIN;
        end else begin
            n_ch = $signed(cacm_pkg::OUT_W'(quo - cacm_pkg::OUT_OFS));
        end
        n_d  = (cacm_pkg::OUT_W + 1)'(n_ch) - (cacm_pkg::OUT_W + 1)'(i_cap);
        n_sq = cacm_pkg::SQ_W'(r_d * r_d);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_py <= n_py;
            r_pa <= n_pa;
            r_pb <= n_pb;
        end
        if (i_en[1]) begin
            r_n <= n_n;
        end
        if (i_en[2]) begin
            r_hi7 <= n_hi;
            r_lo7 <= n_lo;
            r_x   <= n_x;
        end
        if (i_en[3]) begin
            r_ph  <= n_ph;
            r_pl  <= n_pl;
            r_hi8 <= r_hi7;
            r_lo8 <= r_lo7;
        end
        if (i_en[4]) begin
            r_ch9 <= n_ch;
            r_d   <= n_d;
        end
        if (i_en[5]) begin
            r_ch10 <= r_ch9;
            r_sq   <= n_sq;
        end
    end

    assign o_ch = r_ch10;
    assign o_sq = r_sq;

endmodule

// File: design/composite_artifact_colour_model_core.sv
// A result is registered through the lookup, mix, channel and output stages.
// Throughput: one item per cycle unless stalled; each stage has its own enable.
// Table writes take effect at their transfer edge and give no result.
// Reset: synchronous, active low; afterwards the transition banks are swept to
// half scale, row by row through all 128 rows of each bank, with o_stall held high.
// ----------------------------------------------------------------------------
// composite_artifact_colour_model_core
// Composite colour model of a 4-pixel text-mode block, with RGB output and
// squared error against a captured colour.
// ----------------------------------------------------------------------------
module composite_artifact_colour_model_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  cacm_pkg::t_in_item                   i_item,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output cacm_pkg::t_out_item                  o_item,
    input  logic                                 i_cfg_we,
    input  logic [cacm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cacm_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int NS       = cacm_pkg::PIPE_STAGES;
    localparam int CAP_LAST = 8;

    logic [NS+1:1]           en;
    logic [NS:1]             r_v;
    logic [NS:1]             n_vin;
    logic                    in_xfer;
    logic                    eval_xfer;
    logic                    clr_busy;
    cacm_pkg::t_cfg          r_cfg;
    cacm_pkg::t_tbl_wr       tbl_wr;
    cacm_pkg::t_cap          r_cap [1:CAP_LAST];
    cacm_pkg::t_out_item     r_out;
    cacm_pkg::t_out_item     n_out;
    cacm_pkg::t_quad         trans;
    cacm_pkg::t_quad         inten;
    logic [3:0]              ok;
    logic signed [cacm_pkg::Y_W-1:0]   y;
    logic signed [cacm_pkg::CH_W-1:0]  ix;
    logic signed [cacm_pkg::CH_W-1:0]  iq;
    logic signed [cacm_pkg::OUT_W-1:0] ch_r, ch_g, ch_b;
    logic [cacm_pkg::SQ_W-1:0]         sq_r, sq_g, sq_b;

    // Stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        en[NS+1] = !i_stall;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall   = !en[1] || clr_busy;
    assign in_xfer   = i_valid && !o_stall;
    assign eval_xfer = in_xfer && (i_item.kind == cacm_pkg::KIND_EVAL);
    assign n_vin     = {r_v[NS-1:1], eval_xfer};

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_vin[k];
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.contrast_gain     <= cacm_pkg::CONTRAST_RESET;
            r_cfg.brightness_offset <= '0;
            r_cfg.chroma_mult_real  <= '0;
            r_cfg.chroma_mult_imag  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cacm_pkg::CFG_CONTRAST:  r_cfg.contrast_gain     <= i_cfg_data;
                cacm_pkg::CFG_BRIGHT:    r_cfg.brightness_offset <= $signed(i_cfg_data);
                cacm_pkg::CFG_CHROMA_RE: r_cfg.chroma_mult_real  <= $signed(i_cfg_data);
                cacm_pkg::CFG_CHROMA_IM: r_cfg.chroma_mult_imag  <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Table write requests from transferred items
    always_comb begin
        tbl_wr.trans_we = in_xfer && (i_item.kind == cacm_pkg::KIND_TRANS)
                       && (32'(i_item.table_index) < cacm_pkg::TRANSITION_ENTRIES);
        tbl_wr.int_we   = in_xfer && (i_item.kind == cacm_pkg::KIND_INT);
        tbl_wr.index    = i_item.table_index;
        tbl_wr.value    = cacm_pkg::t_sample'(i_item.table_value);
    end

    // Carry the captured colour alongside the datapath
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_cap[1].red   <= i_item.captured_red;
            r_cap[1].green <= i_item.captured_green;
            r_cap[1].blue  <= i_item.captured_blue;
        end
        for (int k = 2; k <= CAP_LAST; k++) begin
            if (en[k]) begin
                r_cap[k] <= r_cap[k-1];
            end
        end
    end

    cacm_lookup u_lookup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en[1]),
        .i_item     (i_item),
        .i_wr       (tbl_wr),
        .o_clr_busy (clr_busy),
        .o_trans    (trans),
        .o_inten    (inten),
        .o_ok       (ok)
    );

    cacm_mix u_mix (
        .i_clk   (i_clk),
        .i_en    (en[4:2]),
        .i_trans (trans),
        .i_inten (inten),
        .i_ok    (ok),
        .i_cfg   (r_cfg),
        .o_y     (y),
        .o_ix    (ix),
        .o_iq    (iq)
    );

    cacm_chan u_chan_r (
        .i_clk (i_clk),
        .i_en  (en[10:5]),
        .i_y   (y),
        .i_ix  (ix),
        .i_iq  (iq),
        .i_ka  (cacm_pkg::KA_R),
        .i_kb  (cacm_pkg::KB_R),
        .i_cap (r_cap[CAP_LAST].red),
        .o_ch  (ch_r),
        .o_sq  (sq_r)
    );

    cacm_chan u_chan_g (
        .i_clk (i_clk),
        .i_en  (en[10:5]),
        .i_y   (y),
        .i_ix  (ix),
        .i_iq  (iq),
        .i_ka  (cacm_pkg::KA_G),
        .i_kb  (cacm_pkg::KB_G),
        .i_cap (r_cap[CAP_LAST].green),
        .o_ch  (ch_g),
        .o_sq  (sq_g)
    );

    cacm_chan u_chan_b (
        .i_clk (i_clk),
        .i_en  (en[10:5]),
        .i_y   (y),
        .i_ix  (ix),
        .i_iq  (iq),
        .i_ka  (cacm_pkg::KA_B),
        .i_kb  (cacm_pkg::KB_B),
        .i_cap (r_cap[CAP_LAST].blue),
        .o_ch  (ch_b),
        .o_sq  (sq_b)
    );

    // Output register: channels and summed error
    always_comb begin
        n_out.red           = ch_r;
        n_out.green         = ch_g;
        n_out.blue          = ch_b;
        n_out.squared_error = cacm_pkg::ERR_W'(sq_r) + cacm_pkg::ERR_W'(sq_g)
                            + cacm_pkg::ERR_W'(sq_b);
    end

    always_ff @(posedge i_clk) begin
        if (en[NS]) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_v[NS];
    assign o_item  = r_out;

endmodule

// File: design/cacm_checker.sv
// ----------------------------------------------------------------------------
// cacm_checker
// Port-level checks of the composite colour model, bound to the top level.
// ----------------------------------------------------------------------------
`include "composite_artifact_colour_model_core_assert.svh"

module cacm_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  o_stall,
    input  cacm_pkg::t_in_item    i_item,
    input  logic                  o_valid,
    input  logic                  i_stall,
    input  cacm_pkg::t_out_item   o_item
);

    localparam int PEND_W = $clog2(cacm_pkg::PIPE_STAGES + 1) + 1;

    logic              eval_xfer;
    logic              out_xfer;
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;

    assign eval_xfer = i_valid && !o_stall && (i_item.kind == cacm_pkg::KIND_EVAL);
    assign out_xfer  = o_valid && !i_stall;

    // Track evaluate items in flight
    always_comb begin
        n_pend = r_pend;
        if (eval_xfer && !out_xfer) begin
            n_pend = r_pend + 1'b1;
        end else if (!eval_xfer && out_xfer) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    `CACM_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_item))
    `CACM_ASSERT_IMP(a_clear_after_reset, !$past(i_rst_n), o_stall)
    `CACM_ASSERT_IMP(a_result_has_item, o_valid, r_pend != '0)
    `CACM_ASSERT_IMP(a_pend_bounded, 1'b1, r_pend <= PEND_W'(cacm_pkg::PIPE_STAGES))

endmodule

bind composite_artifact_colour_model_core cacm_checker u_cacm_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the composite colour model core: table loads,
// register settings and block evaluations, with random idle and stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 4000;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [cacm_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

    typedef enum int { PH_FLOW, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH } t_phase;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    cacm_pkg::t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    cacm_pkg::t_out_item o_item;
    logic      i_cfg_we = 1'b0;
    logic [cacm_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [cacm_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // Predictor state
    logic [15:0] trans_tbl [cacm_pkg::TRANSITION_ENTRIES];
    logic [15:0] inten_tbl [4];
    logic [15:0] gain_q;
    logic signed [15:0] bright_q, mult_re, mult_im;

    cacm_pkg::t_in_item  pending_items [$];
    cacm_pkg::t_out_item expected_colours [$];
    int     fail_count = 0;
    int     eval_count = 0;
    int     result_count = 0;
    int     idle_cycles = 0;
    t_phase phase = PH_FLOW;
    bit     stim_done = 1'b0;
    bit     in_taken = 1'b0;

    composite_artifact_colour_model_core DUT (.*);

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    function automatic longint floor_div(input longint a, input longint d);
        if (a >= 0) return a / d;
        return -((-a + d - 1) / d);
    endfunction

    // Scale to 1/16-level steps, round half up, saturate
    function automatic logic signed [15:0] channel_of(input longint n);
        longint scale, hi, lo, r, v;
        scale = longint'(1) << (cacm_pkg::SAMPLE_BITS + 16);
        hi = floor_div(n, scale);
        lo = n - hi * scale;
        r = lo * 51 + 125 * (scale / 2);
        v = floor_div(hi * 51 + r / scale, 125);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    // Apply a transfer to the tables and return an expected colour if any
    function automatic bit predict_colour(input cacm_pkg::t_in_item it,
                                          output cacm_pkg::t_out_item res);
        longint s [4];
        longint sum4, dx, dy, y, ix, iq, d;
        longint n [3];
        logic [3:0] l, r;
        logic [63:0] err;
        logic signed [15:0] ch [3];
        logic signed [15:0] cap [3];
        res = '0;
        if (it.kind == cacm_pkg::KIND_TRANS) begin
            if (it.table_index < cacm_pkg::TRANSITION_ENTRIES)
                trans_tbl[it.table_index] = it.table_value;
            return 0;
        end
        if (it.kind == cacm_pkg::KIND_INT) begin
            inten_tbl[it.table_index[1:0]] = it.table_value;
            return 0;
        end
        if (it.kind != cacm_pkg::KIND_EVAL) return 0;
        for (int p = 0; p < 4; p++) begin
            l = it.pattern[3 - p] ? it.foreground : it.background;
            r = it.pattern[3 - ((p + 1) % 4)] ? it.foreground : it.background;
            s[p] = longint'(trans_tbl[{l[2:0], 1'b0, r[2:0], p[1:0]}])
                 + longint'(inten_tbl[{r[3], l[3]}]);
        end
        sum4 = s[0] + s[1] + s[2] + s[3];
        dx = s[0] - s[2];
        dy = s[1] - s[3];
        y = sum4 * longint'(gain_q)
          + longint'(bright_q) * (longint'(1) << (cacm_pkg::SAMPLE_BITS + 2));
        ix = (dx * longint'(mult_re) - dy * longint'(mult_im)) * 8;
        iq = (dx * longint'(mult_im) + dy * longint'(mult_re)) * 8;
        n[0] = 10000 * y + 9563 * ix + 6210 * iq;
        n[1] = 10000 * y - 2721 * ix - 6474 * iq;
        n[2] = 10000 * y - 11069 * ix + 17046 * iq;
        cap[0] = it.captured_red;
        cap[1] = it.captured_green;
        cap[2] = it.captured_blue;
        err = 0;
        for (int c = 0; c < 3; c++) begin
            ch[c] = channel_of(n[c]);
            d = longint'(ch[c]) - longint'(cap[c]);
            err += 64'(d * d);
        end
        if (err > 64'hF_FFFF_FFFF) err = 64'hF_FFFF_FFFF;
        res.red = ch[0];
        res.green = ch[1];
        res.blue = ch[2];
        res.squared_error = err[35:0];
        return 1;
    endfunction

    function automatic bit idle_roll(input bit sender);
        bit on;
        on = sender ? (phase == PH_SEND_IDLE || phase == PH_BOTH)
                    : (phase == PH_RECV_STALL || phase == PH_BOTH);
        if (!on) return 0;
        return $urandom_range(99) < ((phase == PH_BOTH) ? 12 : 52);
    endfunction

    // Record whether the presented item was taken at this edge
    always @(posedge i_clk) begin
        in_taken <= i_valid && !o_stall;
    end

    // Driver: hold a stalled transfer, advance on acceptance
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= idle_roll(0);
            if (!i_valid || in_taken) begin
                if (pending_items.size() > 0 && !idle_roll(1)) begin
                    i_item  <= pending_items.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on input transfer, check on output transfer
    always @(posedge i_clk) begin
        cacm_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (predict_colour(i_item, want)) begin
                    expected_colours.push_back(want);
                    eval_count++;
                end
            end
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_colours.size() == 0) begin
                    report_mismatch("unexpected result count", result_count, eval_count);
                end else begin
                    want = expected_colours.pop_front();
                    if (o_item.red !== want.red) report_mismatch("red", o_item.red, want.red);
                    if (o_item.green !== want.green)
                        report_mismatch("green", o_item.green, want.green);
                    if (o_item.blue !== want.blue)
                        report_mismatch("blue", o_item.blue, want.blue);
                    if (o_item.squared_error !== want.squared_error)
                        report_mismatch("squared_error", o_item.squared_error,
                                        want.squared_error);
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else if (!stim_done) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a transfer", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic cacm_pkg::t_in_item random_item();
        cacm_pkg::t_in_item it;
        int pick;
        it = '0;
        it.foreground = 4'($urandom);
        it.background = 4'($urandom);
        it.pattern = 4'($urandom);
        it.table_index = 9'($urandom);
        it.table_value = 16'($urandom);
        it.captured_red = 16'($urandom);
        it.captured_green = 16'($urandom);
        it.captured_blue = 16'($urandom);
        if ($urandom_range(3) != 0) begin
            // Keep captures near plausible colours most of the time
            it.captured_red = 16'($urandom_range(8191));
            it.captured_green = 16'($urandom_range(8191));
            it.captured_blue = 16'($urandom_range(8191));
        end
        pick = $urandom_range(99);
        if (pick < 70) it.kind = cacm_pkg::KIND_EVAL;
        else if (pick < 85) it.kind = cacm_pkg::KIND_TRANS;
        else if (pick < 97) it.kind = cacm_pkg::KIND_INT;
        else it.kind = KIND_SPARE;
        return it;
    endfunction

    task automatic wait_drained();
        wait (pending_items.size() == 0);
        while (expected_colours.size() != 0 || i_valid) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one register at a falling edge, mirror it in the predictor
    task automatic write_reg(input logic [cacm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            cacm_pkg::CFG_CONTRAST:  gain_q = value;
            cacm_pkg::CFG_BRIGHT:    bright_q = value;
            cacm_pkg::CFG_CHROMA_RE: mult_re = value;
            cacm_pkg::CFG_CHROMA_IM: mult_im = value;
            default: ;
        endcase
    endtask

    // Stimulus
    initial begin
        cacm_pkg::t_in_item it;
        logic [15:0] gains [4];
        for (int i = 0; i < cacm_pkg::TRANSITION_ENTRIES; i++) trans_tbl[i] = 16'h8000;
        for (int i = 0; i < 4; i++) inten_tbl[i] = '0;
        gain_q = cacm_pkg::CONTRAST_RESET;
        bright_q = '0;
        mult_re = '0;
        mult_im = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Registers: a moderate colour setting, plus an ignored index
        write_reg(cacm_pkg::CFG_CHROMA_RE, 16'd4096);
        write_reg(cacm_pkg::CFG_CHROMA_IM, 16'd1024);
        write_reg(CFG_SPARE, 16'hFFFF);

        // Directed: table extremes at both ends of the index range, unused kind, evals
        it = '0;
        it.kind = cacm_pkg::KIND_EVAL;
        pending_items.push_back(it);
        it.kind = cacm_pkg::KIND_TRANS; it.table_index = 9'd0; it.table_value = 16'hFFFF;
        pending_items.push_back(it);
        it.table_index = 9'h1FF; it.table_value = 16'h0000;
        pending_items.push_back(it);
        it.table_index = 9'd6; it.table_value = 16'h1234;
        pending_items.push_back(it);
        it.kind = cacm_pkg::KIND_INT; it.table_index = 9'h1FD; it.table_value = 16'hFFFF;
        pending_items.push_back(it);
        it.table_index = 9'd2; it.table_value = 16'h5555;
        pending_items.push_back(it);
        it.kind = KIND_SPARE; it.table_index = 9'd1; it.table_value = 16'hAAAA;
        pending_items.push_back(it);
        for (int k = 0; k < 16; k++) begin
            it = '0;
            it.kind = cacm_pkg::KIND_EVAL;
            it.foreground = 4'(k);
            it.background = 4'(15 - k);
            it.pattern = 4'(k * 5);
            it.captured_red = (k % 2) ? 16'sh7FFF : 16'sh8000;
            it.captured_green = (k % 3) ? 16'sh8000 : 16'sh7FFF;
            it.captured_blue = 16'(k * 4000);
            pending_items.push_back(it);
        end
        wait_drained();

        // Random part over register settings and idle phases
        gains[0] = 16'd0; gains[1] = 16'hFFFF; gains[2] = 16'd16384; gains[3] = 16'd12000;
        for (int set = 0; set < 8; set++) begin
            write_reg(cacm_pkg::CFG_CONTRAST, (set < 4) ? gains[set] : 16'($urandom));
            write_reg(cacm_pkg::CFG_BRIGHT, (set == 1) ? 16'h7FFF :
                                            (set == 2) ? 16'h8000 :
                                            16'($urandom_range(8191)));
            write_reg(cacm_pkg::CFG_CHROMA_RE, (set == 1) ? 16'h7FFF :
                                               (set == 2) ? 16'h8000 : 16'($urandom));
            write_reg(cacm_pkg::CFG_CHROMA_IM, (set == 1) ? 16'h8000 :
                                               (set == 2) ? 16'h7FFF : 16'($urandom));
            phase = t_phase'(set % 4);
            for (int k = 0; k < 190; k++) pending_items.push_back(random_item());
            wait_drained();
        end
        phase = PH_FLOW;
        stim_done = 1'b1;

        $display("Covered %0d evaluations and %0d results over 8 register settings",
                 eval_count, result_count);
        $display("Idle and stall phases: none, sender, receiver, both");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/cacm_pkg.sv
design/cacm_lookup.sv
design/cacm_mix.sv
design/cacm_chan.sv
design/composite_artifact_colour_model_core.sv
design/cacm_checker.sv
dv/tb.sv
